@@ hw/rtl/rccm_pkg.sv @@
// Shared types, constants and lookup tables for the radiation cost merge.
// Used by rccm_cost_pipe and the top level radiation_cell_cost_merge.
`default_nettype none

package rccm_pkg;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_NOISE    = 3'd0,
		REG_CRITICAL = 3'd1,
		REG_INV_SOFT = 3'd2,
		REG_GAIN     = 3'd3,
		REG_CAP      = 3'd4
	} reg_index_t;

	// How a cell's cost is formed once the level is decoded.
	typedef enum logic [1:0] {
		KIND_SKIP,
		KIND_ZERO,
		KIND_CAP,
		KIND_BAND
	} kind_t;

	typedef struct packed {
		logic [14:0] noise;
		logic [14:0] critical;
		logic [15:0] inv_soft;
		logic [15:0] gain;
		logic [7:0]  cap;
	} cfg_t;

	localparam logic [7:0]  WALL_COST  = 8'd254;
	localparam logic [7:0]  CAP_LIMIT  = 8'd252;
	localparam logic [16:0] LOG2E_Q16  = 17'd94548;
	localparam logic [4:0]  EXP_LIMIT  = 5'd24;

	localparam logic [14:0] NOISE_RST    = 15'd3840;
	localparam logic [14:0] CRITICAL_RST = 15'd23040;
	localparam logic [15:0] INV_SOFT_RST = 16'd4369;
	localparam logic [15:0] GAIN_RST     = 16'd435;
	localparam logic [7:0]  CAP_RST      = 8'd252;

	// 2^(k/16) in Q16.16, rounded.
	function automatic logic [17:0] pow2_base(input logic [3:0] k);
		logic [17:0] v;
		case (k)
			4'd0:    v = 18'd65536;
			4'd1:    v = 18'd68438;
			4'd2:    v = 18'd71468;
			4'd3:    v = 18'd74632;
			4'd4:    v = 18'd77936;
			4'd5:    v = 18'd81386;
			4'd6:    v = 18'd84990;
			4'd7:    v = 18'd88752;
			4'd8:    v = 18'd92682;
			4'd9:    v = 18'd96785;
			4'd10:   v = 18'd101070;
			4'd11:   v = 18'd105545;
			4'd12:   v = 18'd110218;
			4'd13:   v = 18'd115098;
			4'd14:   v = 18'd120194;
			default: v = 18'd125515;
		endcase
		return v;
	endfunction

	// Difference to the next table entry, for linear interpolation.
	function automatic logic [12:0] pow2_step(input logic [3:0] k);
		logic [12:0] v;
		case (k)
			4'd0:    v = 13'd2902;
			4'd1:    v = 13'd3030;
			4'd2:    v = 13'd3164;
			4'd3:    v = 13'd3304;
			4'd4:    v = 13'd3450;
			4'd5:    v = 13'd3604;
			4'd6:    v = 13'd3762;
			4'd7:    v = 13'd3930;
			4'd8:    v = 13'd4103;
			4'd9:    v = 13'd4285;
			4'd10:   v = 13'd4475;
			4'd11:   v = 13'd4673;
			4'd12:   v = 13'd4880;
			4'd13:   v = 13'd5096;
			4'd14:   v = 13'd5321;
			default: v = 13'd5557;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rccm_cost_pipe.sv @@
// Seven-stage cost pipeline: level decode, exponent, base-2 conversion,
// table interpolation, shift, gain multiply and final merge. Uses rccm_pkg.
`default_nettype none

module rccm_cost_pipe (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rccm_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_level,
	input  wire logic [7:0]    in_old,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               out_we,
	output logic [7:0]         out_cost
);
	import rccm_pkg::*;

	localparam int NS = 7;
	localparam logic [40:0] ONE_Q16 = 41'h10000;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] old;
	} side_t;

	logic [NS:1] vld_q;
	logic [NS:1] adv;

	// A stage moves on when it is empty or its successor moves on, so bubbles close up.
	always_comb begin
		adv[NS] = !vld_q[NS] || out_ready;
		for (int i = NS - 1; i >= 1; i--) begin
			adv[i] = !vld_q[i] || adv[i + 1];
		end
	end

	assign in_ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) vld_q[1] <= in_valid;
			for (int i = 2; i <= NS; i++) begin
				if (adv[i]) vld_q[i] <= vld_q[i - 1];
			end
		end
	end

	// Stage 1: decode the level against the thresholds.
	side_t       side_s1;
	logic [14:0] x_s1;
	logic [14:0] rq;
	kind_t       kind_d;

	assign rq = {in_level[6:0], 8'd0};

	always_comb begin
		if (in_level[7] || in_old == WALL_COST) kind_d = KIND_SKIP;
		else if (rq <= cfg.noise)               kind_d = KIND_ZERO;
		else if (rq >= cfg.critical)            kind_d = KIND_CAP;
		else                                    kind_d = KIND_BAND;
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			side_s1 <= '{kind: kind_d, old: in_old};
			x_s1    <= rq - cfg.noise;
		end
	end

	// Stage 2: exponent in Q16.16.
	side_t       side_s2;
	logic [22:0] e_s2;
	logic [30:0] mul2;

	assign mul2 = 31'(x_s1) * 31'(cfg.inv_soft);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			side_s2 <= side_s1;
			e_s2    <= mul2[30:8];
		end
	end

	// Stage 3: scale by log2(e) so the power can be taken in base two.
	side_t       side_s3;
	logic [23:0] y_s3;
	logic [39:0] mul3;

	assign mul3 = 40'(e_s2) * 40'(LOG2E_Q16);

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			side_s3 <= side_s2;
			y_s3    <= mul3[39:16];
		end
	end

	// Stage 4: fractional power from the table, interpolated over the low twelve bits.
	side_t       side_s4;
	logic [17:0] p_s4;
	logic [4:0]  n_s4;
	logic        big_s4;
	logic [24:0] mul4;

	assign mul4 = 25'(pow2_step(y_s3[15:12])) * 25'(y_s3[11:0]);

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			side_s4 <= side_s3;
			p_s4    <= pow2_base(y_s3[15:12]) + 18'(mul4[24:12]);
			n_s4    <= y_s3[20:16];
			big_s4  <= y_s3[23:16] >= 8'(EXP_LIMIT);
		end
	end

	// Stage 5: integer power by shifting. Anything past 32 bits saturates later.
	side_t       side_s5;
	logic [31:0] d_s5;
	logic        sat_s5;
	logic [40:0] ex;
	logic [40:0] dx;

	assign ex = 41'(p_s4) << n_s4;
	assign dx = ex - ONE_Q16;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			side_s5 <= side_s4;
			d_s5    <= dx[31:0];
			sat_s5  <= big_s4 || (|dx[40:32]);
		end
	end

	// Stage 6: multiply by the gain.
	side_t       side_s6;
	logic [23:0] c_s6;
	logic        sat_s6;
	logic [47:0] mul6;

	assign mul6 = 48'(d_s5) * 48'(cfg.gain);

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			side_s6 <= side_s5;
			c_s6    <= mul6[47:24];
			sat_s6  <= sat_s5;
		end
	end

	// Stage 7: clamp, take the larger of old and new cost, and hold for the output.
	logic       we_s7;
	logic [7:0] cost_s7;
	logic [7:0] band;
	logic [7:0] cost;

	always_comb begin
		if (sat_s6)                      band = (cfg.gain != '0) ? cfg.cap : 8'd0;
		else if (c_s6 > 24'(cfg.cap))    band = cfg.cap;
		else                             band = c_s6[7:0];
		case (side_s6.kind)
			KIND_ZERO: cost = 8'd0;
			KIND_CAP:  cost = cfg.cap;
			KIND_BAND: cost = band;
			default:   cost = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			we_s7   <= side_s6.kind != KIND_SKIP;
			cost_s7 <= (side_s6.kind == KIND_SKIP || side_s6.old > cost) ? side_s6.old : cost;
		end
	end

	assign out_valid = vld_q[NS];
	assign out_we    = we_s7;
	assign out_cost  = cost_s7;

	// The input side only stalls once every stage holds a word.
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&vld_q))
		else $error("input stalled while a pipeline stage is empty");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[1])
		else $error("accepted word did not enter the first stage");

	// The cap never exceeds 252 and walls are never written, so a write cannot carry 254.
	a_no_wall_write: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NS] && we_s7) |-> (cost_s7 != WALL_COST))
		else $error("written cost equals the wall cost");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NS] && !out_ready) |=> (vld_q[NS] && $stable(cost_s7) && $stable(we_s7)))
		else $error("stalled result changed");

endmodule

`default_nettype wire

@@ hw/rtl/radiation_cell_cost_merge.sv @@
// Top level of the radiation cost merge: configuration registers and the
// stream ports around rccm_cost_pipe. Depends on rccm_pkg.
//
//   channel  dir  handshake            payload (lowest bit first)
//   cfg      in   cfg_we               cfg_index[2:0], cfg_data[15:0]
//   s        in   s_tvalid / s_tready  tdata: radiation_level[7:0], cell_cost[15:8]
//   m        out  m_tvalid / m_tready  tdata: new_cost[7:0]; tuser: write_enable
//
// One word is accepted per cycle while the output is not stalled; each result passes
// through the seven register stages of the cost pipeline.
// Reset clears the stage valid bits and loads the register defaults.
// A stall at the output backs up stage by stage; empty stages still fill.
`default_nettype none

module radiation_cell_cost_merge (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // radiation_level [7:0], cell_cost [15:8]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // new_cost [7:0]
	output logic             m_tuser    // write_enable
);
	import rccm_pkg::*;

	logic [14:0] noise_q;
	logic [14:0] critical_q;
	logic [15:0] inv_soft_q;
	logic [15:0] gain_q;
	logic [7:0]  cap_q;
	cfg_t        cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q    <= NOISE_RST;
			critical_q <= CRITICAL_RST;
			inv_soft_q <= INV_SOFT_RST;
			gain_q     <= GAIN_RST;
			cap_q      <= CAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NOISE:    noise_q    <= cfg_data[14:0];
				REG_CRITICAL: critical_q <= cfg_data[14:0];
				REG_INV_SOFT: inv_soft_q <= cfg_data;
				REG_GAIN:     gain_q     <= cfg_data;
				REG_CAP:      cap_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// The cap is limited so that no computed cost can reach the wall code.
	assign cfg = '{
		noise:    noise_q,
		critical: critical_q,
		inv_soft: inv_soft_q,
		gain:     gain_q,
		cap:      (cap_q > CAP_LIMIT) ? CAP_LIMIT : cap_q
	};

	rccm_cost_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_level  (s_tdata[7:0]),
		.in_old    (s_tdata[15:8]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_we    (m_tuser),
		.out_cost  (m_tdata)
	);

endmodule

`default_nettype wire

@@ verif/tb_radiation_cell_cost_merge.sv @@
`timescale 1ns / 1ps
// Self-checking bench for radiation_cell_cost_merge. It streams cells through the block under
// several register settings and predicts each write from its own fixed-point cost model.
// Depends on rccm_pkg and the RTL of the block.

module tb_radiation_cell_cost_merge;
	import rccm_pkg::*;

	// Predicts the cost written for each cell and holds the writes still due from the block.
	class cell_cost_ledger;
		typedef struct {
			bit         written;
			logic [7:0] cost;
		} cell_write_t;

		cfg_t        regs;
		bit [17:0]   exp2_tab [17];
		cell_write_t due [$];
		int          cells;
		int          results;
		int          errors;

		function new();
			regs.noise    = NOISE_RST;
			regs.critical = CRITICAL_RST;
			regs.inv_soft = INV_SOFT_RST;
			regs.gain     = GAIN_RST;
			regs.cap      = CAP_RST;
			exp2_tab = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
				96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};
			cells = 0;
			results = 0;
			errors = 0;
		endfunction

		function void set_reg(reg_index_t idx, logic [15:0] value);
			case (idx)
				REG_NOISE:    regs.noise = value[14:0];
				REG_CRITICAL: regs.critical = value[14:0];
				REG_INV_SOFT: regs.inv_soft = value;
				REG_GAIN:     regs.gain = value;
				REG_CAP:      regs.cap = value[7:0];
				default:      ;
			endcase
		endfunction

		// Cost between the two thresholds: gain * (2^(x * inv_soft * log2 e) - 1).
		function logic [7:0] band_cost(logic [14:0] x, logic [7:0] cap);
			bit [63:0] e;
			bit [63:0] y;
			bit [63:0] n;
			bit [63:0] p;
			bit [63:0] raw;
			bit [63:0] c;
			int unsigned k;
			bit [63:0] frac;
			e = (64'(x) * 64'(regs.inv_soft)) >> 8;
			y = (e * 64'(LOG2E_Q16)) >> 16;
			n = y >> 16;
			k = 32'(y[15:12]);
			frac = 64'(y[11:0]);
			if (n >= 64'(EXP_LIMIT))
				return (regs.gain != 16'd0) ? cap : 8'd0;
			p = 64'(exp2_tab[k]) + ((64'(exp2_tab[k + 1] - exp2_tab[k]) * frac) >> 12);
			raw = ((p << n) - 64'd65536) * 64'(regs.gain);
			c = raw >> 24;
			return (c > 64'(cap)) ? cap : c[7:0];
		endfunction

		function cell_write_t merged_cost(logic [7:0] level, logic [7:0] old);
			cell_write_t w;
			logic [7:0]  cap;
			logic [14:0] scaled;
			logic [7:0]  cost;
			cap = (regs.cap > CAP_LIMIT) ? CAP_LIMIT : regs.cap;
			w.written = 1'b0;
			w.cost = old;
			// Unknown levels and lethal walls pass through untouched.
			if (level[7] || old == WALL_COST)
				return w;
			scaled = {level[6:0], 8'h00};
			if (scaled <= regs.noise)
				cost = 8'd0;
			else if (scaled >= regs.critical)
				cost = cap;
			else
				cost = band_cost(scaled - regs.noise, cap);
			w.written = 1'b1;
			w.cost = (old > cost) ? old : cost;
			return w;
		endfunction

		function void note_cell(logic [7:0] level, logic [7:0] old);
			due.push_back(merged_cost(level, old));
			cells++;
		endfunction

		function void check_write(logic written, logic [7:0] cost);
			cell_write_t w;
			results++;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: result with none due: write_enable=%0b new_cost=%0d",
					$time, written, cost);
				return;
			end
			w = due.pop_front();
			if (written !== w.written) begin
				errors++;
				$display("%0t: write_enable expected %0b, got %0b", $time, w.written, written);
			end
			if (cost !== w.cost) begin
				errors++;
				$display("%0t: new_cost expected %0d, got %0d", $time, w.cost, cost);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	reg_index_t  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tuser;

	cell_cost_ledger ledger = new();
	bit calm;
	int stall_left = 0;
	int settings_used;

	radiation_cell_cost_merge dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Mostly short gaps with the odd long one; none at all during a calm stretch.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			stall_left = pick_gap();
			if (stall_left == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				stall_left--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			ledger.check_write(m_tuser, m_tdata);
	end

	task automatic send_cell(input logic signed [7:0] level, input logic [7:0] old);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {old, level};
		do @(posedge clk); while (!s_tready);
		ledger.note_cell(level, old);
	endtask

	// Holds the input back until every write already due has come out.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (ledger.due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		ledger.set_reg(idx, value);
	endtask

	task automatic apply_settings(input logic [15:0] noise, input logic [15:0] critical,
			input logic [15:0] inv_soft, input logic [15:0] gain, input logic [15:0] cap);
		write_reg(REG_NOISE, noise);
		write_reg(REG_CRITICAL, critical);
		write_reg(REG_INV_SOFT, inv_soft);
		write_reg(REG_GAIN, gain);
		write_reg(REG_CAP, cap);
		settings_used++;
		calm = ($urandom_range(0, 3) == 0);
	endtask

	task automatic random_settings();
		logic [15:0] noise;
		logic [15:0] critical;
		logic [15:0] inv_soft;
		logic [15:0] gain;
		noise = 16'($urandom_range(0, 24000));
		critical = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767)
			: $urandom_range(noise, 32767));
		inv_soft = 16'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 8000)
			: $urandom_range(1, 65535));
		gain = 16'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 2000)
			: $urandom_range(0, 65535));
		apply_settings(noise, critical, inv_soft, gain, 16'($urandom_range(0, 255)));
	endtask

	// Random cells, weighted towards known levels and low old costs so the band cost shows.
	task automatic run_cells(input int count);
		logic [7:0] level;
		logic [7:0] old;
		int r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			level = (r < 15) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 127));
			r = $urandom_range(0, 99);
			if (r < 8)
				old = WALL_COST;
			else if (r < 14)
				old = 8'd255;
			else if (r < 50)
				old = 8'($urandom_range(0, 40));
			else
				old = 8'($urandom_range(0, 255));
			send_cell(level, old);
			if ($urandom_range(0, 149) == 0)
				drain();
		end
	endtask

	initial begin
		#5_000_000;
		$display("Run timed out with %0d writes still due.", ledger.due.size());
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_NOISE;
		cfg_data = 16'd0;
		s_tvalid = 1'b0;
		s_tdata = 16'd0;
		calm = 1'b0;
		settings_used = 1;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: noise at level 15, critical at level 90.
		send_cell(8'sh80, 8'd0);
		send_cell(-8'sd1, 8'd200);
		send_cell(8'sd127, WALL_COST);
		send_cell(8'sd0, 8'd0);
		send_cell(8'sd15, 8'd0);
		send_cell(8'sd16, 8'd0);
		send_cell(8'sd50, 8'd10);
		send_cell(8'sd89, 8'd0);
		send_cell(8'sd90, 8'd0);
		send_cell(8'sd127, 8'd255);
		send_cell(8'sd127, 8'd253);
		send_cell(8'sd60, 8'd255);
		send_cell(8'sd0, 8'd255);
		send_cell(8'sd40, 8'd128);
		send_cell(8'sd85, 8'd170);
		send_cell(-8'sd64, WALL_COST);
		run_cells(200);
		drain();

		// Widest band, largest gain and a cap above the limit; exponents overflow.
		apply_settings(16'd0, 16'd32767, 16'd65535, 16'd65535, 16'd255);
		calm = 1'b1;
		send_cell(8'sd127, 8'd0);
		send_cell(8'sd1, 8'd0);
		run_cells(150);
		drain();

		// Noise above critical with everything else zero: nothing ever reaches the cap.
		apply_settings(16'd32767, 16'd0, 16'd0, 16'd0, 16'd0);
		run_cells(100);
		drain();

		// Zero reciprocal softness leaves the band cost at zero.
		apply_settings(16'd0, 16'd32767, 16'd0, 16'd1000, 16'd100);
		send_cell(8'sd100, 8'd0);
		run_cells(100);
		drain();

		// Overflowing exponent with zero gain.
		apply_settings(16'd0, 16'd32767, 16'd65535, 16'd0, 16'd200);
		send_cell(8'sd127, 8'd0);
		run_cells(100);
		drain();

		repeat (5) begin
			random_settings();
			run_cells(120);
			drain();
		end

		repeat (16) @(posedge clk);
		$display("Sent %0d cells across %0d register settings; %0d writes checked.",
			ledger.cells, settings_used, ledger.results);
		if (ledger.errors == 0 && ledger.due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d writes never seen.", ledger.errors, ledger.due.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
